/* src/tbt_pkg.sv */
// shared types, widths and helper functions for the triangle barycentric test unit
// no dependencies
`default_nettype none
package tbt_pkg;

    localparam int COORD_BITS  = 13;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_BITS = 24;
    localparam int NUM_COORDS  = 8;
    localparam int NUM_WEIGHTS = 3;

    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int NUM_BITS  = PROD_BITS + 2;
    localparam int QUO_BITS  = WEIGHT_BITS;
    localparam int DIVD_BITS = NUM_BITS + FRAC_BITS;

    localparam int IN_BITS        = NUM_COORDS * COORD_BITS;
    localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS       = NUM_WEIGHTS * WEIGHT_BITS + 2;
    localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS = Q_PTR_BITS + 1;

    localparam logic [WEIGHT_BITS-1:0] W_NEG_LIM = WEIGHT_BITS'(1) << (WEIGHT_BITS - 1);
    localparam logic [WEIGHT_BITS-1:0] W_POS_LIM = W_NEG_LIM - WEIGHT_BITS'(1);
    localparam logic [WEIGHT_BITS-1:0] DEGEN_WEIGHT =
        WEIGHT_BITS'(0) - (WEIGHT_BITS'(1) << FRAC_BITS);

    // classified item handed from the front to the divider back end
    typedef struct packed {
        logic [NUM_WEIGHTS-1:0]               neg;
        logic [NUM_WEIGHTS-1:0]               ovf;
        logic [NUM_WEIGHTS-1:0][NUM_BITS-1:0] mag;
        logic [NUM_BITS-1:0]                  den_mag;
        logic                                 degen;
        logic                                 in_tri;
    } tbt_item_t;

    // one divider pipeline stage
    typedef struct packed {
        tbt_item_t                            item;
        logic [NUM_WEIGHTS-1:0][NUM_BITS-1:0] rem;
        logic [NUM_WEIGHTS-1:0][QUO_BITS-1:0] quo;
    } tbt_div_t;

    function automatic logic [NUM_BITS-1:0] abs_mag(logic signed [NUM_BITS-1:0] v);
        return v[NUM_BITS-1] ? NUM_BITS'(0) - NUM_BITS'(v) : NUM_BITS'(v);
    endfunction

    function automatic logic [WEIGHT_BITS-1:0] sat_weight(logic neg, logic ovf,
                                                           logic [QUO_BITS-1:0] q);
        logic [WEIGHT_BITS-1:0] m;
        if (neg) begin
            m = (ovf || (q > W_NEG_LIM)) ? W_NEG_LIM : q;
            return WEIGHT_BITS'(0) - m;
        end
        m = (ovf || (q > W_POS_LIM)) ? W_POS_LIM : q;
        return m;
    endfunction

endpackage
`default_nettype wire

/* src/tbt_front.sv */
// front end: edge differences, cross products, numerators and classification
// depends on tbt_pkg
`default_nettype none
module tbt_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tbt_pkg::IN_TDATA_BITS-1:0] s_tdata,
    input  wire logic                              q_full,
    output logic                                   q_push,
    output tbt_pkg::tbt_item_t                     q_item
);

    localparam int C = tbt_pkg::COORD_BITS;
    localparam int D = tbt_pkg::DIFF_BITS;
    localparam int P = tbt_pkg::PROD_BITS;
    localparam int N = tbt_pkg::NUM_BITS;

    logic signed [C-1:0] ax, ay, bx, by, cx, cy, px, py;
    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [D-1:0] acx_reg, abx_reg, pax_reg, acy_reg, aby_reg, pay_reg;
    logic signed [P-1:0] p_abx_pay_reg, p_pax_aby_reg, p_pax_acy_reg;
    logic signed [P-1:0] p_acx_pay_reg, p_acx_aby_reg, p_abx_acy_reg;
    logic signed [N-1:0] n1_reg, n2_reg, n3_reg, den_reg;
    logic signed [N-1:0] n2_next, n3_next, den_next;
    tbt_pkg::tbt_item_t  item_reg, item_next;

    assign ax = s_tdata[0*C +: C];
    assign ay = s_tdata[1*C +: C];
    assign bx = s_tdata[2*C +: C];
    assign by = s_tdata[3*C +: C];
    assign cx = s_tdata[4*C +: C];
    assign cy = s_tdata[5*C +: C];
    assign px = s_tdata[6*C +: C];
    assign py = s_tdata[7*C +: C];

    assign en       = !(v4_reg && q_full);
    assign s_tready = en;
    assign q_push   = v4_reg && !q_full;
    assign q_item   = item_reg;

    assign n3_next  = N'(p_abx_pay_reg) - N'(p_pax_aby_reg);
    assign n2_next  = N'(p_pax_acy_reg) - N'(p_acx_pay_reg);
    assign den_next = N'(p_acx_aby_reg) - N'(p_abx_acy_reg);

    always_comb begin
        logic signed [N-1:0] nums [tbt_pkg::NUM_WEIGHTS];
        nums[0] = n1_reg;
        nums[1] = n2_reg;
        nums[2] = n3_reg;
        item_next.den_mag = tbt_pkg::abs_mag(den_reg);
        item_next.degen   = (den_reg == '0);
        item_next.in_tri  = (den_reg != '0);
        for (int w = 0; w < tbt_pkg::NUM_WEIGHTS; w++) begin
            item_next.mag[w] = tbt_pkg::abs_mag(nums[w]);
            item_next.neg[w] = nums[w][N-1] != den_reg[N-1];
            // quotient needs more than the weight width
            item_next.ovf[w] = (item_next.mag[w] >> (tbt_pkg::QUO_BITS - tbt_pkg::FRAC_BITS))
                               >= item_next.den_mag;
            if (nums[w] != '0 && item_next.neg[w]) begin
                item_next.in_tri = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acx_reg <= D'(cx) - D'(ax);
            abx_reg <= D'(bx) - D'(ax);
            pax_reg <= D'(ax) - D'(px);
            acy_reg <= D'(cy) - D'(ay);
            aby_reg <= D'(by) - D'(ay);
            pay_reg <= D'(ay) - D'(py);

            p_abx_pay_reg <= P'(abx_reg) * P'(pay_reg);
            p_pax_aby_reg <= P'(pax_reg) * P'(aby_reg);
            p_pax_acy_reg <= P'(pax_reg) * P'(acy_reg);
            p_acx_pay_reg <= P'(acx_reg) * P'(pay_reg);
            p_acx_aby_reg <= P'(acx_reg) * P'(aby_reg);
            p_abx_acy_reg <= P'(abx_reg) * P'(acy_reg);

            n2_reg  <= n2_next;
            n3_reg  <= n3_next;
            den_reg <= den_next;
            n1_reg  <= den_next - n2_next - n3_next;

            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

/* src/tbt_queue.sv */
// short fifo of classified items between front and back
// depends on tbt_pkg
`default_nettype none
module tbt_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  tbt_pkg::tbt_item_t      push_item,
    input  wire logic               pop,
    output tbt_pkg::tbt_item_t      head_item,
    output logic                    full,
    output logic                    empty
);

    tbt_pkg::tbt_item_t              mem_reg [tbt_pkg::Q_DEPTH];
    logic [tbt_pkg::Q_PTR_BITS-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [tbt_pkg::Q_CNT_BITS-1:0]  cnt_reg;
    logic                            do_pop;

    assign full      = (cnt_reg == tbt_pkg::Q_CNT_BITS'(tbt_pkg::Q_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign head_item = mem_reg[rd_ptr_reg];
    assign do_pop    = pop && !empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (!push && do_pop) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

/* src/tbt_back.sv */
// back end: pipelined restoring dividers, one quotient bit per stage, and saturation
// depends on tbt_pkg
`default_nettype none
module tbt_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  tbt_pkg::tbt_item_t                      head_item,
    input  wire logic                               empty,
    output logic                                    pop,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [tbt_pkg::OUT_TDATA_BITS-1:0]      m_tdata
);

    localparam int QB = tbt_pkg::QUO_BITS;
    localparam int NB = tbt_pkg::NUM_BITS;
    localparam int NW = tbt_pkg::NUM_WEIGHTS;
    localparam int WB = tbt_pkg::WEIGHT_BITS;

    tbt_pkg::tbt_div_t st_reg [QB+1];
    tbt_pkg::tbt_div_t st_next [QB+1];
    logic [QB:0]       sv_reg;
    logic              en;
    logic              out_valid_reg;
    logic [tbt_pkg::OUT_TDATA_BITS-1:0] out_data_reg, out_data_next;

    assign en       = !out_valid_reg || m_tready;
    assign pop      = en && !empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // first stage: partial remainder holds the dividend bits above the quotient
    always_comb begin
        logic [tbt_pkg::DIVD_BITS-1:0] dvd;
        st_next[0].item = head_item;
        for (int w = 0; w < NW; w++) begin
            dvd = {head_item.mag[w], {tbt_pkg::FRAC_BITS{1'b0}}};
            st_next[0].rem[w] = NB'(dvd >> QB);
            st_next[0].quo[w] = '0;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_step
        localparam int B = QB - 1 - k;
        always_comb begin
            logic [tbt_pkg::DIVD_BITS-1:0] dvd;
            logic [NB:0]                   trial;
            st_next[k+1] = st_reg[k];
            for (int w = 0; w < NW; w++) begin
                dvd   = {st_reg[k].item.mag[w], {tbt_pkg::FRAC_BITS{1'b0}}};
                trial = {st_reg[k].rem[w], dvd[B]};
                if (trial >= {1'b0, st_reg[k].item.den_mag}) begin
                    st_next[k+1].rem[w]    = NB'(trial - {1'b0, st_reg[k].item.den_mag});
                    st_next[k+1].quo[w][B] = 1'b1;
                end else begin
                    st_next[k+1].rem[w] = NB'(trial);
                end
            end
        end
    end

    always_comb begin
        logic [NW-1:0][WB-1:0] w_out;
        for (int w = 0; w < NW; w++) begin
            w_out[w] = st_reg[QB].item.degen ? tbt_pkg::DEGEN_WEIGHT :
                       tbt_pkg::sat_weight(st_reg[QB].item.neg[w], st_reg[QB].item.ovf[w],
                                           st_reg[QB].quo[w]);
        end
        out_data_next = tbt_pkg::OUT_TDATA_BITS'({st_reg[QB].item.in_tri,
                                                  st_reg[QB].item.degen, w_out});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            sv_reg        <= {sv_reg[QB-1:0], !empty};
            out_valid_reg <= sv_reg[QB];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k <= QB; k++) begin
                st_reg[k] <= st_next[k];
            end
            out_data_reg <= out_data_next;
        end
    end

endmodule
`default_nettype wire

/* src/triangle_barycentric_test_unit.sv */
// an accepted input beat passes to its result beat through
// 4 front stages, the queue memory, 25 divider stages and 1 output register
// throughput: one beat per cycle while m_tready does not stall the output, set by the bit-per-stage divider pipeline
// reset: synchronous active-low aresetn clears all valid bits, queue pointers and counts
// top level: front end, item queue and divider back end; depends on tbt_pkg
`default_nettype none
module triangle_barycentric_test_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
    // point_x, point_y
    input  wire logic [tbt_pkg::IN_TDATA_BITS-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // weight_first, weight_second, weight_third, degenerate, inside_res, zero fill
    output logic [tbt_pkg::OUT_TDATA_BITS-1:0]     m_tdata
);

    tbt_pkg::tbt_item_t push_item, head_item;
    logic q_push, q_pop, q_full, q_empty;

    tbt_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    tbt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    tbt_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_item (head_item),
        .empty     (q_empty),
        .pop       (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

/* src/tbt_checker.sv */
// port-level checks for the triangle barycentric test unit, bound to the top level
// depends on tbt_pkg
`default_nettype none
module tbt_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [tbt_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    localparam int WB = tbt_pkg::WEIGHT_BITS;
    localparam int DG = 3 * WB;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // degenerate triangles give minus one everywhere and are never inside
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DG] |->
            !m_tdata[DG+1] && m_tdata[WB-1:0] == tbt_pkg::DEGEN_WEIGHT &&
            m_tdata[2*WB-1:WB] == tbt_pkg::DEGEN_WEIGHT &&
            m_tdata[3*WB-1:2*WB] == tbt_pkg::DEGEN_WEIGHT)
        else $error("degenerate beat malformed");

    // inside implies no weight is negative
    a_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DG+1] |->
            !m_tdata[WB-1] && !m_tdata[2*WB-1] && !m_tdata[3*WB-1])
        else $error("inside beat with negative weight");

endmodule

bind triangle_barycentric_test_unit tbt_checker u_tbt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
